### sv/audio_distortion_clipper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distortion clipper
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AUDIO_DISTORTION_CLIPPER_ASSERT_SVH
`define AUDIO_DISTORTION_CLIPPER_ASSERT_SVH

`ifndef SYNTHESIS

`define ADC_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("adc assertion failed");

`define ADC_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("adc assertion failed");

`else

`define ADC_ASSERT_IMPL(lbl, a, b)

`define ADC_ASSERT_NEXT(lbl, a, b)

`endif

`endif

### sv/adc_pkg.sv
// ----------------------------------------------------------------------------
// adc_pkg
// Shared types for the distortion clipper: mode codes, soft-clip regions,
// the per-beat control word and queue status.
// ----------------------------------------------------------------------------
`default_nettype none

package adc_pkg;

  typedef enum logic [1:0] {
    MODE_HARD = 2'd0,
    MODE_SOFT = 2'd1,
    MODE_FULL = 2'd2,
    MODE_HALF = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CLS_LINEAR   = 3'd0,
    CLS_KNEE_POS = 3'd1,
    CLS_KNEE_NEG = 3'd2,
    CLS_CLIP_POS = 3'd3,
    CLS_CLIP_NEG = 3'd4
  } soft_cls_t;

  typedef struct packed {
    mode_t     mode;
    soft_cls_t cls;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic afull;
  } q_stat_t;

  localparam int unsigned CfgAddrW = 3;

  localparam logic [CfgAddrW-1:0] ADDR_MODE = 3'd0;
  localparam logic [CfgAddrW-1:0] ADDR_GAIN = 3'd4;

endpackage

`default_nettype wire

### sv/adc_front.sv
// ----------------------------------------------------------------------------
// adc_front
// Gain multiply, truncate and saturate to Q1.x, then classify the sample
// for the soft-clip knee and push one beat into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_front import adc_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic signed [SAMPLE_WIDTH-1:0] gain,
  input  wire mode_t                          mode,
  output logic                                push,
  output logic signed [SAMPLE_WIDTH-1:0]      push_v,
  output ctrl_t                               push_ctrl
);

  localparam int W = SAMPLE_WIDTH;
  localparam longint FONE_L = longint'(1) << (W - 1);
  localparam longint T1_L = (FONE_L + 6) / 12;
  localparam longint T2_L = (FONE_L + 3) / 6;

  localparam logic signed [2*W-1:0] PMAX = (2*W)'(FONE_L - 1);
  localparam logic signed [2*W-1:0] PMIN = -(2*W)'(FONE_L);
  localparam logic signed [W-1:0] VMAX = W'(FONE_L - 1);
  localparam logic signed [W-1:0] VMIN = W'(-FONE_L);
  localparam logic signed [W-1:0] T1 = W'(T1_L);
  localparam logic signed [W-1:0] T2 = W'(T2_L);

  logic                    f_valid_r, f_valid_nxt;
  logic signed [2*W-1:0]   f_prod_r, f_prod_nxt;
  mode_t                   f_mode_r, f_mode_nxt;
  logic signed [2*W-1:0]   shf;
  logic signed [W-1:0]     v;
  soft_cls_t               cls;

  always_comb begin
    f_valid_nxt = accept;
    f_prod_nxt  = f_prod_r;
    f_mode_nxt  = f_mode_r;
    if (accept) begin
      f_prod_nxt = (2*W)'(sample) * (2*W)'(gain);
      f_mode_nxt = mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    f_prod_r <= f_prod_nxt;
    f_mode_r <= f_mode_nxt;
  end

  always_comb begin
    shf = f_prod_r >>> (W - 1);
    if (shf > PMAX) begin
      v = VMAX;
    end else if (shf < PMIN) begin
      v = VMIN;
    end else begin
      v = shf[W-1:0];
    end
    if (v > T2) begin
      cls = CLS_CLIP_POS;
    end else if (v > T1) begin
      cls = CLS_KNEE_POS;
    end else if (v < -T2) begin
      cls = CLS_CLIP_NEG;
    end else if (v < -T1) begin
      cls = CLS_KNEE_NEG;
    end else begin
      cls = CLS_LINEAR;
    end
  end

  assign push           = f_valid_r;
  assign push_v         = v;
  assign push_ctrl.mode = f_mode_r;
  assign push_ctrl.cls  = cls;

endmodule

`default_nettype wire

### sv/adc_queue.sv
// ----------------------------------------------------------------------------
// adc_queue
// Short register queue between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_distortion_clipper_assert.svh"

module adc_queue import adc_pkg::*; #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output q_stat_t               stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PLAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CDEPTH = CW'(DEPTH);
  localparam logic [CW-1:0] CAFULL = CW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = push && (count_r != CDEPTH);
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PLAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PLAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CDEPTH);
  assign stat.afull = (count_r >= CAFULL);

  `ADC_ASSERT_IMPL(a_q_no_overflow, push && stat.full, pop)
  `ADC_ASSERT_IMPL(a_q_count_range, 1'b1, count_r <= CDEPTH)

endmodule

`default_nettype wire

### sv/adc_back.sv
// ----------------------------------------------------------------------------
// adc_back
// Square the sample for the knee, then apply the selected distortion and
// the saturating times-four gain, and register the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_distortion_clipper_assert.svh"

module adc_back import adc_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_v,
  input  wire ctrl_t                          in_ctrl,
  output logic                                out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample
);

  localparam int W = SAMPLE_WIDTH;
  localparam int E = SAMPLE_WIDTH + 6;
  localparam longint FONE_L = longint'(1) << (W - 1);

  localparam logic signed [E-1:0] EMAX = E'(FONE_L - 1);
  localparam logic signed [E-1:0] EMIN = E'(-FONE_L);
  localparam logic signed [E-1:0] HCLIP = E'(FONE_L / 8);
  localparam logic signed [E-1:0] QTR = E'(FONE_L / 4);
  localparam logic signed [E-1:0] THIRD = E'((FONE_L + 1) / 3);
  localparam logic signed [E-1:0] TWELVE = E'(12);

  function automatic logic signed [E-1:0] sat_e(input logic signed [E-1:0] x);
    logic signed [E-1:0] r;
    if (x > EMAX) begin
      r = EMAX;
    end else if (x < EMIN) begin
      r = EMIN;
    end else begin
      r = x;
    end
    return r;
  endfunction

  logic                  a_valid_r, a_valid_nxt;
  logic signed [W-1:0]   a_v_r, a_v_nxt;
  logic [W-1:0]          a_q_r, a_q_nxt;
  ctrl_t                 a_ctrl_r, a_ctrl_nxt;
  logic signed [2*W-1:0] sq;

  logic                  o_valid_r, o_valid_nxt;
  logic signed [W-1:0]   o_sample_r, o_sample_nxt;

  logic signed [E-1:0]   ve, qe, y, x, res;

  always_comb begin
    sq          = (2*W)'(in_v) * (2*W)'(in_v);
    a_valid_nxt = in_valid;
    a_v_nxt     = in_v;
    a_q_nxt     = sq[2*W-2:W-1];
    a_ctrl_nxt  = in_ctrl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
    a_v_r    <= a_v_nxt;
    a_q_r    <= a_q_nxt;
    a_ctrl_r <= a_ctrl_nxt;
  end

  always_comb begin
    ve = E'(a_v_r);
    qe = $signed({{(E-W){1'b0}}, a_q_r});
    y  = '0;
    case (a_ctrl_r.mode)
      MODE_HARD: begin
        if (ve > HCLIP) begin
          x = HCLIP;
        end else if (ve < -HCLIP) begin
          x = -HCLIP;
        end else begin
          x = ve;
        end
      end
      MODE_SOFT: begin
        case (a_ctrl_r.cls)
          CLS_LINEAR:   y = ve <<< 1;
          CLS_KNEE_POS: y = QTR - THIRD + (ve <<< 2) - TWELVE * qe;
          CLS_KNEE_NEG: y = -QTR + THIRD + (ve <<< 2) + TWELVE * qe;
          CLS_CLIP_POS: y = QTR;
          CLS_CLIP_NEG: y = -QTR;
          default:      y = '0;
        endcase
        x = sat_e(y) >>> 1;
      end
      MODE_FULL: begin
        x = (ve < 0) ? sat_e(-ve) : ve;
      end
      MODE_HALF: begin
        x = (ve < 0) ? '0 : ve;
      end
      default: begin
        x = '0;
      end
    endcase
    res          = sat_e(x <<< 2);
    o_valid_nxt  = a_valid_r;
    o_sample_nxt = res[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
    end
    o_sample_r <= o_sample_nxt;
  end

  assign out_valid  = o_valid_r;
  assign out_sample = o_sample_r;

  `ADC_ASSERT_NEXT(a_back_stage_flow, a_valid_r, o_valid_r)

endmodule

`default_nettype wire

### sv/audio_distortion_clipper.sv
// ----------------------------------------------------------------------------
// audio_distortion_clipper
// Gain stage followed by hard clip, soft clip, full-wave or half-wave
// rectification of signed Q1.x audio samples.
//
//   channel   ports                          handshake
//   input     start, busy, in_sample_in      beat on start && !busy
//   result    out_strobe, out_sample_out     one-cycle strobe, no stall
//   config    psel .. pready, paddr, pwdata  APB write, pready tied high
//
// One sample per cycle sustained. From accept to strobe a beat passes the
// product register, queue, square register and output register.
// Synchronous active-low reset clears the pipeline and queue, mode to hard
// clip and gain to max positive. busy rises only when the queue nears full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_distortion_clipper_assert.svh"

module audio_distortion_clipper import adc_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int QUEUE_DEPTH  = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                                out_strobe,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample_out,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [CfgAddrW-1:0]            paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int W = SAMPLE_WIDTH;
  localparam int QW = W + $bits(ctrl_t);
  localparam logic signed [W-1:0] GAIN_RST = {1'b0, {(W-1){1'b1}}};

  mode_t               mode_r, mode_nxt;
  logic signed [W-1:0] gain_r, gain_nxt;
  logic                wr_en;
  logic                accept;

  logic                push;
  logic signed [W-1:0] push_v;
  ctrl_t               push_ctrl;
  logic [QW-1:0]       q_rdata;
  q_stat_t             q_stat;
  logic                pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    mode_nxt = mode_r;
    gain_nxt = gain_r;
    if (wr_en) begin
      if (paddr[2] == ADDR_GAIN[2]) begin
        gain_nxt = pwdata[W-1:0];
      end else begin
        mode_nxt = mode_t'(pwdata[1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HARD;
      gain_r <= GAIN_RST;
    end else begin
      mode_r <= mode_nxt;
      gain_r <= gain_nxt;
    end
  end

  assign prdata = (paddr[2] == ADDR_GAIN[2]) ? 32'($unsigned(gain_r))
                                             : 32'(mode_r);

  assign busy   = q_stat.afull;
  assign accept = start && !busy;

  adc_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .sample    (in_sample_in),
    .gain      (gain_r),
    .mode      (mode_r),
    .push      (push),
    .push_v    (push_v),
    .push_ctrl (push_ctrl)
  );

  adc_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({push_ctrl, push_v}),
    .pop   (pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  assign pop = !q_stat.empty;

  adc_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pop),
    .in_v       (q_rdata[W-1:0]),
    .in_ctrl    (ctrl_t'(q_rdata[QW-1:W])),
    .out_valid  (out_strobe),
    .out_sample (out_sample_out)
  );

  `ADC_ASSERT_IMPL(a_top_latency, accept, ##4 out_strobe)

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: distortion clipper gain and mode check
// Drives signed samples through the command port under random start gaps and
// retunes mode and gain over the APB port between phases. Each beat's output
// is set by the table or predicted from current mode and gain, matched in
// order against the strobed result. A directed table covers the range ends,
// every mode, gain overflow, rectifier sign handling and the soft-clip knee.
// ----------------------------------------------------------------------------
module tb_top;
  import adc_pkg::*;

  localparam int  SW        = 24;
  localparam int  RAND_BEATS = 125;
  localparam int  PHASES    = 8;
  localparam int  STALL_MAX = 2000;

  localparam logic signed [SW-1:0] S_MAX  = 24'sh7FFFFF;
  localparam logic signed [SW-1:0] S_MIN  = 24'sh800000;
  localparam logic signed [SW-1:0] S_ZERO = 24'sh000000;
  localparam logic signed [SW-1:0] Y_HI   = 24'sh400000;
  localparam logic signed [SW-1:0] Y_LO   = 24'shC00000;

  localparam longint F_ONE   = 64'sd8388608;
  localparam longint F_MAX   = F_ONE - 1;
  localparam longint F_MIN   = -F_ONE;
  localparam longint EIGHTH  = F_ONE / 8;
  localparam longint QUARTER = F_ONE / 4;
  localparam longint THIRD   = (F_ONE + 1) / 3;
  localparam longint KNEE_LO = (F_ONE + 6) / 12;
  localparam longint KNEE_HI = (F_ONE + 3) / 6;

  typedef struct packed {
    mode_t                mode;
    logic signed [SW-1:0] gain;
    logic signed [SW-1:0] smp;
    bit                   known;
    logic signed [SW-1:0] want;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [SW-1:0] in_sample_in;
  logic                 out_strobe;
  logic signed [SW-1:0] out_sample_out;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CfgAddrW-1:0]  paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  mode_t                cur_mode;
  logic signed [SW-1:0] cur_gain;
  logic signed [SW-1:0] exp_samples[$];
  dir_row_t             dir_rows[0:19];
  bit                   gaps_on;
  int                   err_cnt;
  int                   stall_cnt;

  audio_distortion_clipper #(.SAMPLE_WIDTH(SW)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_sample_in   (in_sample_in),
    .out_strobe     (out_strobe),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint sat_q(longint x);
    if (x > F_MAX) return F_MAX;
    if (x < F_MIN) return F_MIN;
    return x;
  endfunction

  function automatic logic signed [SW-1:0] distort_predict(logic signed [SW-1:0] smp);
    longint v;
    longint y;
    longint r;
    v = sat_q((longint'(smp) * longint'(cur_gain)) >>> (SW - 1));
    case (cur_mode)
      MODE_HARD: begin
        if (v > EIGHTH) v = EIGHTH;
        else if (v < -EIGHTH) v = -EIGHTH;
        r = sat_q(v * 4);
      end
      MODE_SOFT: begin
        if (v > KNEE_HI) y = QUARTER;
        else if (v > KNEE_LO) y = sat_q(QUARTER - THIRD + 4 * v - 12 * ((v * v) >>> (SW - 1)));
        else if (v < -KNEE_HI) y = -QUARTER;
        else if (v < -KNEE_LO) y = sat_q(THIRD - QUARTER + 4 * v + 12 * ((v * v) >>> (SW - 1)));
        else y = sat_q(2 * v);
        r = sat_q((y >>> 1) * 4);
      end
      MODE_FULL: r = sat_q(((v < 0) ? sat_q(-v) : v) * 4);
      default:   r = sat_q(((v < 0) ? 64'sd0 : v) * 4);
    endcase
    return r[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    logic signed [SW-1:0] s;
    case ($urandom_range(3))
      0: s = SW'($urandom_range(1600000));
      1: s = -SW'($urandom_range(1600000));
      2: case ($urandom_range(4))
           0: s = S_MAX;
           1: s = S_MIN;
           2: s = S_ZERO;
           3: s = 24'sh000001;
           default: s = 24'shFFFFFF;
         endcase
      default: s = SW'($urandom);
    endcase
    return s;
  endfunction

  // Enter and leave at a falling edge; start stays high for a following beat.
  task automatic send_sample(logic signed [SW-1:0] smp, bit known, logic signed [SW-1:0] want);
    while (gaps_on && $urandom_range(99) < 34) begin
      start <= 1'b0;
      in_sample_in <= SW'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    in_sample_in <= smp;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_samples.push_back(known ? want : distort_predict(smp));
    @(negedge clk);
  endtask

  task automatic apb_write(logic [CfgAddrW-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // If forced or if mode or gain differ, drain the pipe, then write both registers with junk in the unused bits.
  task automatic retune(mode_t m, logic signed [SW-1:0] g, bit always_wr);
    if (always_wr || m != cur_mode || g != cur_gain) begin
      start <= 1'b0;
      @(negedge clk);
      while (exp_samples.size() != 0) @(negedge clk);
      apb_write(ADDR_MODE, ($urandom & ~32'h3) | 32'(m));
      cur_mode = m;
      apb_write(ADDR_GAIN, ($urandom & 32'hFF00_0000) | {8'h00, g});
      cur_gain = g;
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (exp_samples.size() == 0) begin
        $display("%0t: unexpected sample_out beat, got %0d", $time, out_sample_out);
        err_cnt++;
      end else if (out_sample_out !== exp_samples[0]) begin
        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                 $time, exp_samples[0], out_sample_out);
        err_cnt++;
        void'(exp_samples.pop_front());
      end else begin
        void'(exp_samples.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_MAX) begin
      $display("audio_distortion_clipper test failed");
      $finish;
    end
  end

  initial begin
    mode_t                m;
    logic signed [SW-1:0] g;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_sample_in = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    err_cnt      = 0;
    stall_cnt    = 0;
    gaps_on      = 1'b1;
    cur_mode     = MODE_HARD;
    cur_gain     = S_MAX;

    dir_rows = '{
      '{MODE_HARD, S_MAX,        S_ZERO,        1'b1, S_ZERO},
      '{MODE_HARD, S_MAX,        S_MAX,         1'b1, Y_HI},
      '{MODE_HARD, S_MAX,        S_MIN,         1'b1, Y_LO},
      '{MODE_HARD, S_MAX,        24'sh000001,   1'b0, S_ZERO},
      '{MODE_HARD, S_MAX,        24'shFFFFFF,   1'b0, S_ZERO},
      '{MODE_HARD, S_MIN,        S_MIN,         1'b1, Y_HI},
      '{MODE_HARD, S_ZERO,       S_MAX,         1'b1, S_ZERO},
      '{MODE_SOFT, S_MAX,        S_ZERO,        1'b1, S_ZERO},
      '{MODE_SOFT, S_MAX,        S_MAX,         1'b1, Y_HI},
      '{MODE_SOFT, S_MAX,        S_MIN,         1'b1, Y_LO},
      '{MODE_SOFT, S_MAX,        24'sd699052,   1'b0, S_ZERO},
      '{MODE_SOFT, S_MAX,        24'sd900000,   1'b0, S_ZERO},
      '{MODE_SOFT, S_MAX,        -24'sd900000,  1'b0, S_ZERO},
      '{MODE_SOFT, S_MAX,        24'sd1398102,  1'b0, S_ZERO},
      '{MODE_SOFT, S_MAX,        -24'sd1398102, 1'b0, S_ZERO},
      '{MODE_FULL, S_MAX,        S_MIN,         1'b1, S_MAX},
      '{MODE_FULL, S_MIN,        S_MIN,         1'b1, S_MAX},
      '{MODE_FULL, S_MAX,        -24'sd1000,    1'b0, S_ZERO},
      '{MODE_HALF, S_MAX,        S_MIN,         1'b1, S_ZERO},
      '{MODE_HALF, 24'sh400000,  24'sh100000,   1'b0, S_ZERO}
    };

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      retune(dir_rows[i].mode, dir_rows[i].gain, 1'b0);
      send_sample(dir_rows[i].smp, dir_rows[i].known, dir_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      m = mode_t'(p % 4);
      case (p)
        0:       g = S_MAX;
        3:       g = S_MIN;
        5:       g = 24'sh000001;
        6:       g = 24'sh400000;
        default: g = SW'($urandom);
      endcase
      retune(m, g, 1'b1);
      gaps_on = (p != 2);
      for (int k = 0; k < RAND_BEATS; k++)
        send_sample(rand_sample(), 1'b0, S_ZERO);
    end

    start <= 1'b0;
    while (exp_samples.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("audio_distortion_clipper test passed");
    end else begin
      $display("audio_distortion_clipper test failed");
    end
    $finish;
  end

endmodule
